// ----- rtl/core/mat_pkg.sv -----
// Package for the multiplexed alarm timer: field types, operation codes and
// delay conversion constants. No dependencies.
package mat_pkg;

  localparam int HW_CH    = 8;
  localparam int OP_W     = 2;
  localparam int SLOT_W   = 3;
  localparam int PERIOD_W = 32;
  localparam int STAMP_W  = 64;
  localparam int DELAY_W  = 22;
  localparam int WORD_W   = 1 + PERIOD_W + STAMP_W;

  typedef logic [OP_W-1:0]     op_t;
  typedef logic [SLOT_W-1:0]   slot_t;
  typedef logic [PERIOD_W-1:0] period_t;
  typedef logic [STAMP_W-1:0]  stamp_t;
  typedef logic [DELAY_W-1:0]  delay_t;
  typedef logic [WORD_W-1:0]   word_t;

  localparam op_t OP_START = 2'd0;
  localparam op_t OP_STOP  = 2'd1;
  localparam op_t OP_TICK  = 2'd2;
  localparam op_t OP_QUERY = 2'd3;

  localparam stamp_t SIGN_BIT  = 64'h8000_0000_0000_0000;
  localparam stamp_t MS_DIV    = 64'd1000;
  // smallest time whose millisecond count exceeds DELAY_MAX
  localparam stamp_t SAT_LIMIT = 64'd2147484000;
  localparam delay_t DELAY_MAX = 22'd2147483;
  localparam delay_t DELAY_ONE = 22'd1;

  // t / 1000 == ((t >> 3) * ceil(2^36 / 125)) >> 36 for t below SAT_LIMIT
  localparam int PRE_SHIFT   = 3;
  localparam int RECIP_W     = 30;
  localparam int RECIP_SHIFT = 36;
  localparam logic [RECIP_W-1:0] MS_RECIP = 30'd549755814;

endpackage

// ----- rtl/core/mat_if.sv -----
// Request and response channel interfaces of the alarm timer.
// Depends on mat_pkg.
interface mat_req_if;
  import mat_pkg::*;
  logic    valid;
  logic    ready;
  op_t     op;
  slot_t   slot;
  period_t period;
  stamp_t  now;
  logic    repeat_req;
  modport source (output valid, op, slot, period, now, repeat_req, input ready);
  modport sink   (input valid, op, slot, period, now, repeat_req, output ready);
endinterface

interface mat_rsp_if;
  import mat_pkg::*;
  logic   valid;
  logic   ready;
  logic   kind;
  slot_t  fired_slot;
  logic   pending;
  logic   armed;
  logic   rearmed;
  delay_t delay_ms;
  logic   last;
  modport source (output valid, kind, fired_slot, pending, armed, rearmed, delay_ms, last,
                  input ready);
  modport sink   (input valid, kind, fired_slot, pending, armed, rearmed, delay_ms, last,
                  output ready);
endinterface

// ----- rtl/core/multiplexed_alarm_timer.sv -----
// Multiplexed alarm timer: up to eight alarm channels sharing one service timer.
// Depends on mat_pkg, mat_req_if, mat_rsp_if, mat_ram, mat_ms_conv.
//
// Usage: req carries one operation per transaction (start, stop, service tick,
// query). rsp returns the results of that operation: a fired transaction for each
// expired channel during a tick, then one status transaction with last set.
// Channel count is min(SLOTS, 8); deadline, period and repeat bit live in one
// RAM word per channel, active bits and the armed deadline in flip-flops.
// Path from request to status: stop and query go straight to status; start
// adds and compares the deadline, then converts the delay when it re-arms;
// a tick scans every channel, converts when it re-arms, and waits on rsp for
// each fired transaction. A tick reads one channel per cycle unless rsp stalls,
// through a 3-stage read/compute/update pipeline on the RAM port.
// req is ready only between operations; one operation is in flight at a time,
// and a new request is taken while the last status still waits in rsp.
// A stalled rsp freezes the tick scan at the next fired transaction.
// Reset clears active bits, the armed flag and the output valid; RAM contents
// are not cleared; a tick reads every word, but only active channels are used.
module multiplexed_alarm_timer #(
  parameter int SLOTS = 8
) (
  input  logic      clk,
  input  logic      rst,
  mat_req_if.sink   req,
  mat_rsp_if.source rsp
);
  import mat_pkg::*;

  localparam int NCH = (SLOTS < HW_CH) ? SLOTS : HW_CH;
  localparam int AW  = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int CW  = $clog2(NCH + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ST_ADD = 3'd1;
  localparam logic [2:0] S_ST_CMP = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_CONV   = 3'd4;
  localparam logic [2:0] S_STATUS = 3'd5;

  logic [2:0]       state;
  logic [NCH-1:0]   active;
  logic [HW_CH-1:0] act_ext;
  logic             timer_armed;
  stamp_t           armed_deadline;
  logic             re_r;
  delay_t           dly_r;

  slot_t   slot_r;
  period_t period_r;
  stamp_t  now_r;
  logic    rep_r;
  stamp_t  dl_r;

  logic [CW-1:0] rd_idx;
  logic          c_vld;
  logic [AW-1:0] c_idx;
  logic          u_vld;
  logic [AW-1:0] u_idx;
  stamp_t        u_left;
  stamp_t        u_dl;
  stamp_t        u_newdl;
  logic          u_exp;
  logic          u_rep;
  period_t       u_period;
  logic          found;
  stamp_t        best_key;
  stamp_t        best_dl;

  logic   out_valid;
  logic   out_kind;
  slot_t  out_fired_slot;
  logic   out_pending;
  logic   out_armed;
  logic   out_rearmed;
  delay_t out_delay;
  logic   out_last;

  logic          accept;
  logic          req_slot_ok;
  logic          slot_ok;
  logic [AW-1:0] sidx;
  logic          out_free;
  logic          u_active;
  logic          u_fire;
  logic          u_cand;
  logic          stall;
  logic          adv;
  logic          issue;
  logic          take;
  logic          scan_done;
  stamp_t        cand_left;
  stamp_t        cand_key;
  stamp_t        cand_dl;
  logic          r_rep;
  period_t       r_period;
  stamp_t        r_dl;
  stamp_t        c_left;
  stamp_t        c_newdl;
  logic          c_exp;
  stamp_t        cmp_d;
  logic          st_re;
  logic          ev_load;
  logic          st_load;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  word_t         ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  word_t         ram_rdata;

  logic   conv_start;
  stamp_t conv_t;
  logic   conv_done;
  delay_t conv_delay;

  assign accept      = req.valid && req.ready;
  assign req.ready   = (state == S_IDLE);
  assign req_slot_ok = int'(req.slot) < NCH;
  assign slot_ok     = int'(slot_r) < NCH;
  assign sidx        = slot_r[AW-1:0];
  assign act_ext     = HW_CH'(active);
  assign out_free    = !out_valid || rsp.ready;

  assign r_rep    = ram_rdata[WORD_W-1];
  assign r_period = ram_rdata[STAMP_W +: PERIOD_W];
  assign r_dl     = ram_rdata[STAMP_W-1:0];
  assign c_left   = r_dl - now_r;
  assign c_newdl  = r_dl + STAMP_W'(r_period);
  assign c_exp    = (c_left == '0) || c_left[STAMP_W-1];

  assign u_active  = active[u_idx];
  assign u_fire    = u_vld && u_active && u_exp;
  assign u_cand    = u_vld && u_active && (!u_exp || u_rep);
  assign stall     = u_fire && !out_free;
  assign adv       = (state == S_SCAN) && !stall;
  assign issue     = adv && (rd_idx != CW'(NCH));
  assign cand_left = u_exp ? (u_left + STAMP_W'(u_period)) : u_left;
  assign cand_key  = cand_left ^ SIGN_BIT;
  assign cand_dl   = u_exp ? u_newdl : u_dl;
  assign take      = adv && u_cand && (!found || (cand_key < best_key));
  assign scan_done = (state == S_SCAN) && (rd_idx == CW'(NCH)) && !c_vld && !u_vld;

  assign cmp_d = armed_deadline - dl_r;
  assign st_re = !timer_armed || ((cmp_d != '0) && !cmp_d[STAMP_W-1]);

  assign ev_load = adv && u_fire;
  assign st_load = (state == S_STATUS) && out_free;

  assign conv_start = ((state == S_ST_CMP) && st_re) || (scan_done && found);
  assign conv_t     = (state == S_SCAN) ? (best_key ^ SIGN_BIT) : STAMP_W'(period_r);

  assign ram_we    = ((state == S_ST_ADD) && slot_ok) || (adv && u_fire && u_rep);
  assign ram_waddr = (state == S_ST_ADD) ? sidx : u_idx;
  assign ram_wdata = (state == S_ST_ADD) ? {rep_r, period_r, now_r + STAMP_W'(period_r)}
                                         : {u_rep, u_period, u_newdl};
  assign ram_re    = issue;
  assign ram_raddr = rd_idx[AW-1:0];

  mat_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NCH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mat_ms_conv u_conv (
    .clk      (clk),
    .rst      (rst),
    .start    (conv_start),
    .t        (conv_t),
    .done     (conv_done),
    .delay_ms (conv_delay)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      active      <= '0;
      timer_armed <= 1'b0;
      re_r        <= 1'b0;
      rd_idx      <= '0;
      c_vld       <= 1'b0;
      u_vld       <= 1'b0;
      found       <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      out_valid <= ev_load || st_load || (out_valid && !rsp.ready);
      case (state)
        S_IDLE: begin
          if (accept) begin
            re_r <= 1'b0;
            case (req.op)
              OP_START: state <= S_ST_ADD;
              OP_STOP: begin
                if (req_slot_ok) begin
                  active[req.slot[AW-1:0]] <= 1'b0;
                end
                state <= S_STATUS;
              end
              OP_TICK: begin
                rd_idx <= '0;
                c_vld  <= 1'b0;
                u_vld  <= 1'b0;
                found  <= 1'b0;
                state  <= S_SCAN;
              end
              default: state <= S_STATUS;
            endcase
          end
        end
        S_ST_ADD: begin
          if (slot_ok) begin
            active[sidx] <= 1'b1;
            state        <= S_ST_CMP;
          end else begin
            state <= S_STATUS;
          end
        end
        S_ST_CMP: begin
          if (st_re) begin
            timer_armed <= 1'b1;
            re_r        <= 1'b1;
            state       <= S_CONV;
          end else begin
            state <= S_STATUS;
          end
        end
        S_SCAN: begin
          if (adv) begin
            if (issue) begin
              rd_idx <= rd_idx + 1'b1;
            end
            c_vld <= issue;
            u_vld <= c_vld;
            if (u_fire && !u_rep) begin
              active[u_idx] <= 1'b0;
            end
            if (take) begin
              found <= 1'b1;
            end
          end
          if (scan_done) begin
            if (found) begin
              timer_armed <= 1'b1;
              re_r        <= 1'b1;
              state       <= S_CONV;
            end else begin
              timer_armed <= 1'b0;
              state       <= S_STATUS;
            end
          end
        end
        S_CONV: begin
          if (conv_done) begin
            state <= S_STATUS;
          end
        end
        S_STATUS: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      slot_r   <= req.slot;
      period_r <= req.period;
      now_r    <= req.now;
      rep_r    <= req.repeat_req;
    end
    if (state == S_ST_ADD) begin
      dl_r <= now_r + STAMP_W'(period_r);
    end
    if ((state == S_ST_CMP) && st_re) begin
      armed_deadline <= dl_r;
    end
    if (scan_done && found) begin
      armed_deadline <= best_dl;
    end
    if (issue) begin
      c_idx <= rd_idx[AW-1:0];
    end
    if (adv && c_vld) begin
      u_idx    <= c_idx;
      u_left   <= c_left;
      u_dl     <= r_dl;
      u_newdl  <= c_newdl;
      u_exp    <= c_exp;
      u_rep    <= r_rep;
      u_period <= r_period;
    end
    if (take) begin
      best_key <= cand_key;
      best_dl  <= cand_dl;
    end
    if ((state == S_CONV) && conv_done) begin
      dly_r <= conv_delay;
    end
    if (ev_load) begin
      out_kind       <= 1'b0;
      out_fired_slot <= SLOT_W'(u_idx);
      out_pending    <= u_rep;
      out_armed      <= 1'b0;
      out_rearmed    <= 1'b0;
      out_delay      <= '0;
      out_last       <= 1'b0;
    end
    if (st_load) begin
      out_kind       <= 1'b1;
      out_fired_slot <= '0;
      out_pending    <= act_ext[slot_r];
      out_armed      <= timer_armed;
      out_rearmed    <= re_r;
      out_delay      <= re_r ? dly_r : '0;
      out_last       <= 1'b1;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.kind       = out_kind;
  assign rsp.fired_slot = out_fired_slot;
  assign rsp.pending    = out_pending;
  assign rsp.armed      = out_armed;
  assign rsp.rearmed    = out_rearmed;
  assign rsp.delay_ms   = out_delay;
  assign rsp.last       = out_last;

endmodule

// ----- rtl/core/mat_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/mat_ms_conv.sv -----
// Three-stage microsecond to millisecond delay conversion:
// max(1, t/1000) saturated, negative t gives 1. Depends on mat_pkg.
module mat_ms_conv (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  mat_pkg::stamp_t t,
  output logic            done,
  output mat_pkg::delay_t delay_ms
);
  import mat_pkg::*;

  localparam int X_W    = PERIOD_W - PRE_SHIFT;
  localparam int PROD_W = X_W + RECIP_W;

  logic              v1;
  logic              v2;
  logic              one1;
  logic              sat1;
  logic              one2;
  logic              sat2;
  logic [X_W-1:0]    x1;
  logic [PROD_W-1:0] prod2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= start;
      v2   <= v1;
      done <= v2;
    end
  end

  always_ff @(posedge clk) begin
    x1       <= t[PERIOD_W-1:PRE_SHIFT];
    one1     <= t[STAMP_W-1] || (t < MS_DIV);
    sat1     <= !t[STAMP_W-1] && (t >= SAT_LIMIT);
    prod2    <= PROD_W'(x1) * PROD_W'(MS_RECIP);
    one2     <= one1;
    sat2     <= sat1;
    delay_ms <= one2 ? DELAY_ONE : (sat2 ? DELAY_MAX : prod2[RECIP_SHIFT +: DELAY_W]);
  end

endmodule
